[sv/kwtl_pkg.sv]
// Types, keyword tables and character codes shared by the keyword token lexer.
package kwtl_pkg;

    localparam int NKW = 9;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_IDENT   = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_COMMENT = 2'd3
    } t_mode;

    typedef logic [3:0] t_kind;

    localparam t_kind KIND_END    = 4'd0;
    localparam t_kind KIND_IDENT  = 4'd10;
    localparam t_kind KIND_NUMBER = 4'd11;
    localparam t_kind KIND_SINGLE = 4'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Keyword text, right-justified: the last character sits in the lowest byte.
    localparam logic [63:0] KW_TEXT [NKW] = '{
        64'("function"), 64'("extern"), 64'("if"), 64'("else"), 64'("for"),
        64'("from"), 64'("to"), 64'("variable"), 64'("execute")
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd8, 4'd6, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2, 4'd8, 4'd7
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] tok_char;
        logic [7:0] length;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_scan;

endpackage

[sv/keyword_token_lexer_core.sv]
// Top level of the keyword token lexer: character stream in, token stream out.
// One character item is taken per cycle while s_axis_tready is high; lexing is
// done in the cycle it is accepted and its zero, one or two tokens go into a
// four-entry result queue. s_axis_tready stays high while the queue has room
// for two tokens, so items are taken back to back whenever the output side
// keeps up; a character that ends a pending token and is itself a token puts
// two tokens into the queue, which registers every token before the output.
// Token length saturates at the smaller of MAX_TOKEN_LEN and 255.
module keyword_token_lexer_core #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] token_kind, [11:4] token_char,
                                        // [19:12] token_length, [23:20] zero
    output logic        m_axis_tlast    // last
);
    import kwtl_pkg::*;

    localparam int QDEPTH = 4;

    t_result    r_queue [QDEPTH];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;

    logic    accept, pop;
    t_scan   scan;
    t_result head;

    assign s_axis_tready = (r_cnt <= 3'(QDEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    kwtl_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_scan   (scan)
    );

    always_comb begin
        n_wr  = accept ? r_wr + scan.count : r_wr;
        n_rd  = pop ? r_rd + 2'd1 : r_rd;
        n_cnt = r_cnt + (accept ? {1'b0, scan.count} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && scan.count != 2'd0) begin
            r_queue[r_wr] <= scan.res0;
        end
        if (accept && scan.count == 2'd2) begin
            r_queue[r_wr + 2'd1] <= scan.res1;
        end
    end

    assign head         = r_queue[r_rd];
    assign m_axis_tdata = {4'b0000, head.length, head.tok_char, head.kind};
    assign m_axis_tlast = head.last;

endmodule

[sv/kwtl_scan.sv]
// Lexer state and the token results caused by one character item.
module kwtl_scan #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_ch,
    input  logic           i_end,
    output kwtl_pkg::t_scan o_scan
);
    import kwtl_pkg::*;

    localparam int         LEN_CAP = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
    localparam logic [7:0] LEN_MAX = 8'(LEN_CAP);
    localparam logic [NKW-1:0] ALIVE_ALL = '1;

    t_mode          r_mode, n_mode;
    logic [NKW-1:0] r_alive, n_alive;
    logic [7:0]     r_len, n_len;

    logic    is_alpha, is_digit, is_space, is_break;
    logic    consumed, pending, start_ident, start_num;
    t_result flush_res;
    t_kind   ident_kind;

    function automatic logic [NKW-1:0] extend_alive(input logic [7:0] p,
                                                     input logic [NKW-1:0] alive,
                                                     input logic [7:0] c);
        logic [NKW-1:0] res;
        logic [2:0]     idx;
        logic           ok;
        res = alive;
        for (int k = 0; k < NKW; k++) begin
            idx = 3'(KW_LEN[k] - 4'd1) - p[2:0];
            ok  = (p < {4'b0000, KW_LEN[k]}) && (KW_TEXT[k][{idx, 3'b000} +: 8] == c);
            if (!ok) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    always_comb begin
        is_alpha    = (i_ch inside {[8'h61:8'h7A], [8'h41:8'h5A]});
        is_digit    = (i_ch inside {[8'h30:8'h39]});
        is_space    = (i_ch == CH_SPACE) || (i_ch inside {[8'h09:8'h0D]});
        is_break    = (i_ch == CH_NUL) || (i_ch == CH_LF) || (i_ch == CH_CR);
        consumed    = ((r_mode == MODE_IDENT) && (is_alpha || is_digit || i_ch == CH_UNDER))
                   || ((r_mode == MODE_NUMBER) && (is_digit || i_ch == CH_DOT));
        pending     = (r_mode == MODE_IDENT) || (r_mode == MODE_NUMBER);
        start_ident = is_alpha || (i_ch == CH_HASH);
        start_num   = is_digit;
    end

    always_comb begin
        ident_kind = KIND_IDENT;
        for (int k = NKW - 1; k >= 0; k--) begin
            if (r_alive[k] && (r_len == {4'b0000, KW_LEN[k]})) begin
                ident_kind = 4'(k + 1);
            end
        end
        flush_res.kind     = (r_mode == MODE_IDENT) ? ident_kind : KIND_NUMBER;
        flush_res.tok_char = 8'd0;
        flush_res.length   = r_len;
        flush_res.last     = 1'b0;
    end

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_alive = r_alive;
        n_len   = r_len;
        if (i_end) begin
            n_mode  = MODE_IDLE;
            n_alive = ALIVE_ALL;
            n_len   = 8'd0;
        end else if (r_mode == MODE_COMMENT) begin
            if (is_break) begin
                n_mode  = MODE_IDLE;
                n_alive = ALIVE_ALL;
                n_len   = 8'd0;
            end
        end else if (consumed) begin
            n_alive = extend_alive(r_len, r_alive, i_ch);
            n_len   = (r_len < LEN_MAX) ? r_len + 8'd1 : r_len;
        end else begin
            n_mode  = MODE_IDLE;
            n_alive = ALIVE_ALL;
            n_len   = 8'd0;
            if (start_ident) begin
                n_mode  = MODE_IDENT;
                n_alive = extend_alive(8'd0, ALIVE_ALL, i_ch);
                n_len   = 8'd1;
            end else if (start_num) begin
                n_mode  = MODE_NUMBER;
                n_alive = extend_alive(8'd0, ALIVE_ALL, i_ch);
                n_len   = 8'd1;
            end else if (i_ch == CH_PCT) begin
                n_mode  = MODE_COMMENT;
            end
        end
    end

    // results
    always_comb begin
        t_result end_res;
        t_result single_res;
        end_res          = '0;
        end_res.kind     = KIND_END;
        single_res       = '0;
        single_res.kind  = KIND_SINGLE;
        single_res.tok_char = i_ch;
        o_scan = '0;
        if (i_end) begin
            end_res.last = 1'b1;
            if (pending) begin
                o_scan.res0  = flush_res;
                o_scan.res1  = end_res;
                o_scan.count = 2'd2;
            end else begin
                o_scan.res0  = end_res;
                o_scan.count = 2'd1;
            end
        end else if (r_mode == MODE_COMMENT) begin
            if (i_ch == CH_NUL) begin
                single_res.last = 1'b1;
                o_scan.res0     = single_res;
                o_scan.count    = 2'd1;
            end
        end else if (!consumed) begin
            single_res.last = 1'b1;
            if (!is_space && !start_ident && !start_num && i_ch != CH_PCT) begin
                if (pending) begin
                    o_scan.res0  = flush_res;
                    o_scan.res1  = single_res;
                    o_scan.count = 2'd2;
                end else begin
                    o_scan.res0  = single_res;
                    o_scan.count = 2'd1;
                end
            end else if (pending) begin
                o_scan.res0      = flush_res;
                o_scan.res0.last = 1'b1;
                o_scan.count     = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_alive <= ALIVE_ALL;
            r_len   <= 8'd0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_alive <= n_alive;
            r_len   <= n_len;
        end
    end

endmodule
